// File: hdl/sfcs_pkg.sv
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types and constants of the SPI flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned LenW   = 16;
  localparam int unsigned PageW  = 13;
  localparam int unsigned ByteW  = 8;

  // Flash command codes of the 25-series command set.
  localparam logic [7:0] CmdWren = 8'h06;
  localparam logic [7:0] CmdRdsr = 8'h05;
  localparam logic [7:0] CmdRead = 8'h03;
  localparam logic [7:0] CmdPp   = 8'h02;
  localparam logic [7:0] CmdSe   = 8'hD8;
  localparam logic [7:0] CmdBe   = 8'hC7;
  localparam int unsigned StatusBusyBit = 0;
  localparam logic [PageW-1:0] PageSizeReset = 13'd256;

  // Input item kinds.
  typedef enum logic [2:0] {
    KIND_READ   = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_WDATA  = 3'd2,
    KIND_SERASE = 3'd3,
    KIND_BERASE = 3'd4,
    KIND_REPLY  = 3'd5
  } kind_e;

  // Operations handed from the front part to the back part.
  typedef enum logic [3:0] {
    OP_ERR   = 4'd0,
    OP_NOP   = 4'd1,
    OP_READ  = 4'd2,
    OP_CHUNK = 4'd3,
    OP_SE    = 4'd4,
    OP_BE    = 4'd5,
    OP_POLL  = 4'd6,
    OP_RDATA = 4'd7,
    OP_WDATA = 4'd8
  } op_e;

  // One request for the back part: all it needs to emit the result bytes.
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic             fin;
    logic             busy;
  } desc_t;

endpackage

// File: hdl/spi_flash_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_core
// Turns host requests and flash replies into a 25-series SPI byte stream.
// ----------------------------------------------------------------------------
// Each accepted request yields one to seven result items, which the back end
// delivers one per cycle as long as the output is ready, while the front end
// keeps accepting items into a two-entry queue. A write start, and each
// program chunk resumed after a status poll, holds the input while a
// bit-serial unit works out the address offset inside the page bit by bit,
// and until the chunk is handed over, longer while the queue is full; all
// other items are taken as soon as the queue has room. The page-size register
// sits at byte address 0 and may be written only while the block is idle.
module spi_flash_command_sequencer_core import sfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [23:0] address, [39:24] length, [47:40] data_byte
  input  logic [47:0] s_axis_tdata_i,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] send_valid, [8:1] send_byte, [9] deselect, [10] host_valid,
  // [18:11] host_data, [19] busy_res, [20] error, rest zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PageW-1:0] pg_bytes_q;
  logic             q_full, q_empty, push, pop;
  desc_t            push_desc, pop_desc;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-PageW){1'b0}}, pg_bytes_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_bytes_q <= PageSizeReset;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      pg_bytes_q <= pwdata[PageW-1:0];
    end
  end

  sfcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .address_i   (s_axis_tdata_i[23:0]),
    .length_i    (s_axis_tdata_i[39:24]),
    .data_byte_i (s_axis_tdata_i[47:40]),
    .pg_bytes_i  (pg_bytes_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  sfcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_desc_o  (pop_desc)
  );

  sfcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_desc_i    (pop_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: hdl/sfcs_rem.sv
// ----------------------------------------------------------------------------
// sfcs_rem
// Restoring remainder unit: address modulo page size, one bit per cycle.
// ----------------------------------------------------------------------------
module sfcs_rem import sfcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AddrW-1:0] dividend_i,
  input  logic [PageW-1:0] divisor_i,
  output logic             busy_o,
  output logic [PageW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(AddrW + 1);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] dvd_q, dvd_d;
  logic [PageW-1:0] div_q, div_d;
  logic [PageW-1:0] rem_q, rem_d;
  logic [PageW:0]   trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[AddrW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(AddrW);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = PageW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[PageW-1:0];
      end
      dvd_d = {dvd_q[AddrW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// File: hdl/sfcs_front.sv
// ----------------------------------------------------------------------------
// sfcs_front
// Accepts input items, tracks the flash phase and issues back-end requests.
// ----------------------------------------------------------------------------
module sfcs_front import sfcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       kind_i,
  input  logic [AddrW-1:0] address_i,
  input  logic [LenW-1:0]  length_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic [PageW-1:0] pg_bytes_i,
  input  logic             q_full_i,
  output logic             push_o,
  output desc_t            push_desc_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_READ  = 4'b0010,
    PH_WDATA = 4'b0100,
    PH_POLL  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    F_ACCEPT = 2'b01,
    F_DIV    = 2'b10
  } fstate_e;

  phase_e           phase_q, phase_d;
  fstate_e          fst_q, fst_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [PageW-1:0] pleft_q, pleft_d;
  logic             resume_q, resume_d;

  logic             accept;
  logic             div_start;
  logic [AddrW-1:0] div_dvd;
  logic [PageW-1:0] ps_eff;
  logic             div_busy;
  logic [PageW-1:0] div_rem;
  logic [PageW:0]   room;
  logic [LenW-1:0]  left_dec;
  logic [PageW-1:0] pleft_dec;
  logic             wfin;

  assign ps_eff     = (pg_bytes_i == '0) ? PageW'(1) : pg_bytes_i;
  assign in_ready_o = (fst_q == F_ACCEPT) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign left_dec   = left_q - 1'b1;
  assign pleft_dec  = pleft_q - 1'b1;
  assign wfin       = (pleft_dec == '0) || (left_dec == '0);
  assign room       = {1'b0, ps_eff} - {1'b0, div_rem};

  sfcs_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (ps_eff),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // Classify the item against the current phase and update the state.
  always_comb begin
    phase_d     = phase_q;
    fst_d       = fst_q;
    addr_d      = addr_q;
    left_d      = left_q;
    pleft_d     = pleft_q;
    resume_d    = resume_q;
    div_start   = 1'b0;
    div_dvd     = addr_q;
    push_o      = 1'b0;
    push_desc_o = '{op: OP_ERR, addr: addr_q, data: data_byte_i, fin: 1'b0,
                    busy: (phase_q != PH_IDLE)};
    if (fst_q == F_DIV) begin
      // Chunk start once the page offset is known.
      push_desc_o.op   = OP_CHUNK;
      push_desc_o.busy = 1'b1;
      if (!div_busy && !q_full_i) begin
        push_o = 1'b1;
        if ({{(LenW-PageW-1){1'b0}}, room} < left_q) begin
          pleft_d = room[PageW-1:0];
        end else begin
          pleft_d = left_q[PageW-1:0];
        end
        fst_d = F_ACCEPT;
      end
    end else if (accept) begin
      push_o = 1'b1;
      case (phase_q)
        PH_IDLE: begin
          if (kind_i == KIND_READ) begin
            addr_d = address_i;
            left_d = length_i;
            push_desc_o.op   = OP_READ;
            push_desc_o.addr = address_i;
            push_desc_o.fin  = (length_i == '0);
            push_desc_o.busy = (length_i != '0);
            if (length_i != '0) begin
              phase_d = PH_READ;
            end
          end else if (kind_i == KIND_WRITE) begin
            addr_d   = address_i;
            left_d   = length_i;
            resume_d = 1'b0;
            if (length_i == '0) begin
              push_desc_o.op   = OP_NOP;
              push_desc_o.busy = 1'b0;
            end else begin
              push_o    = 1'b0;
              div_start = 1'b1;
              div_dvd   = address_i;
              phase_d   = PH_WDATA;
              fst_d     = F_DIV;
            end
          end else if (kind_i == KIND_SERASE) begin
            resume_d = 1'b0;
            phase_d  = PH_POLL;
            push_desc_o.op   = OP_SE;
            push_desc_o.addr = address_i;
            push_desc_o.busy = 1'b1;
          end else if (kind_i == KIND_BERASE) begin
            resume_d = 1'b0;
            phase_d  = PH_POLL;
            push_desc_o.op   = OP_BE;
            push_desc_o.busy = 1'b1;
          end
        end
        PH_READ: begin
          if (kind_i == KIND_REPLY) begin
            left_d = left_dec;
            addr_d = addr_q + 1'b1;
            push_desc_o.op   = OP_RDATA;
            push_desc_o.fin  = (left_dec == '0);
            push_desc_o.busy = (left_dec != '0);
            if (left_dec == '0) begin
              phase_d = PH_IDLE;
            end
          end
        end
        PH_WDATA: begin
          if (kind_i == KIND_WDATA) begin
            left_d  = left_dec;
            pleft_d = pleft_dec;
            addr_d  = addr_q + 1'b1;
            push_desc_o.op  = OP_WDATA;
            push_desc_o.fin = wfin;
            push_desc_o.busy = 1'b1;
            if (wfin) begin
              resume_d = (left_dec != '0);
              phase_d  = PH_POLL;
            end
          end
        end
        PH_POLL: begin
          if (kind_i == KIND_REPLY) begin
            if (data_byte_i[StatusBusyBit]) begin
              push_desc_o.op   = OP_POLL;
              push_desc_o.busy = 1'b1;
            end else if (resume_q) begin
              resume_d  = 1'b0;
              push_o    = 1'b0;
              div_start = 1'b1;
              div_dvd   = addr_q;
              phase_d   = PH_WDATA;
              fst_d     = F_DIV;
            end else begin
              push_desc_o.op   = OP_NOP;
              push_desc_o.busy = 1'b0;
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      fst_q    <= F_ACCEPT;
      addr_q   <= '0;
      left_q   <= '0;
      pleft_q  <= '0;
      resume_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fst_q    <= fst_d;
      addr_q   <= addr_d;
      left_q   <= left_d;
      pleft_q  <= pleft_d;
      resume_q <= resume_d;
    end
  end

endmodule

// File: hdl/sfcs_queue.sv
// ----------------------------------------------------------------------------
// sfcs_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfcs_queue import sfcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t pop_desc_o
);

  desc_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_desc_o = mem_q[rptr_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

// File: hdl/sfcs_back.sv
// ----------------------------------------------------------------------------
// sfcs_back
// Expands one queued request into its result items, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module sfcs_back import sfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  desc_t       q_desc_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] out_data_o,
  output logic        out_last_o
);

  logic       active_q;
  desc_t      cur_q;
  logic [2:0] step_q;

  logic       sv, desel, hv, err, lst;
  logic [7:0] sb, hd;

  // Result table indexed by operation and step.
  always_comb begin
    sv = 1'b1; desel = 1'b0; hv = 1'b0; err = 1'b0; lst = 1'b0;
    sb = '0; hd = '0;
    case (cur_q.op)
      OP_ERR: begin
        sv = 1'b0; err = 1'b1; lst = 1'b1;
      end
      OP_NOP: begin
        sv = 1'b0; lst = 1'b1;
      end
      OP_READ, OP_CHUNK, OP_SE: begin
        case (step_q)
          3'd0: begin sb = CmdWren; desel = 1'b1; end
          3'd1: sb = (cur_q.op == OP_READ) ? CmdRead :
                     (cur_q.op == OP_CHUNK) ? CmdPp : CmdSe;
          3'd2: sb = cur_q.addr[23:16];
          3'd3: sb = cur_q.addr[15:8];
          3'd4: begin
            sb = cur_q.addr[7:0];
            desel = (cur_q.op == OP_SE) || (cur_q.op == OP_READ && cur_q.fin);
            lst = (cur_q.op == OP_CHUNK) || (cur_q.op == OP_READ && cur_q.fin);
          end
          3'd5: begin
            sb  = (cur_q.op == OP_SE) ? CmdRdsr : 8'h00;
            lst = (cur_q.op == OP_READ);
          end
          default: begin sb = 8'h00; desel = 1'b1; lst = 1'b1; end
        endcase
      end
      OP_BE: begin
        case (step_q)
          3'd0: begin sb = CmdWren; desel = 1'b1; end
          3'd1: begin sb = CmdBe; desel = 1'b1; end
          3'd2: sb = CmdRdsr;
          default: begin sb = 8'h00; desel = 1'b1; lst = 1'b1; end
        endcase
      end
      OP_POLL: begin
        if (step_q == 3'd0) begin
          sb = CmdRdsr;
        end else begin
          desel = 1'b1; lst = 1'b1;
        end
      end
      OP_RDATA: begin
        sv = !cur_q.fin; desel = cur_q.fin; hv = 1'b1; hd = cur_q.data;
        lst = 1'b1;
      end
      OP_WDATA: begin
        case (step_q)
          3'd0: begin sb = cur_q.data; desel = cur_q.fin; lst = !cur_q.fin; end
          3'd1: sb = CmdRdsr;
          default: begin desel = 1'b1; lst = 1'b1; end
        endcase
      end
      default: begin
        sv = 1'b0; err = 1'b1; lst = 1'b1;
      end
    endcase
  end

  assign out_valid_o = active_q;
  assign out_last_o  = lst;
  assign out_data_o  = {3'b000, err, cur_q.busy, hd, hv, desel, sb, sv};
  assign pop_o       = !q_empty_i && (!active_q || (out_ready_i && lst));

  // Step sequencing and request loading.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      step_q   <= '0;
    end else if (active_q && out_ready_i) begin
      if (lst) begin
        active_q <= 1'b0;
      end
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_desc_i;
    end
  end

endmodule
